// File: src/apfs_pkg.sv
// package for the arrival priority fcfs scheduler
// holds record layout, widths and the compare function; no dependencies
package apfs_pkg;

    localparam int unsigned MaxProcsDefault = 16;
    localparam int unsigned IdW   = 16;
    localparam int unsigned TimeW = 16;
    localparam int unsigned StatW = 20;
    localparam int unsigned ClkW  = 22;

    typedef struct packed {
        logic [IdW-1:0]   burst;
        logic [TimeW-1:0] arrival;
        logic             proc_class;
        logic [IdW-1:0]   proc_id;
    } t_rec;

    // x runs before y: earlier arrival, or same arrival and x of class 1 where y is of class 0
    function automatic logic runs_before(input t_rec x, input t_rec y);
        logic r;
        if (x.arrival != y.arrival) begin
            r = (x.arrival < y.arrival);
        end else begin
            r = x.proc_class & ~y.proc_class;
        end
        return r;
    endfunction

endpackage

// File: src/apfs_table.sv
// record table: one synchronous memory, one write and one read port
// depends on apfs_pkg for the record type
module apfs_table #(
    parameter int unsigned MAX_PROCS = apfs_pkg::MaxProcsDefault,
    localparam int unsigned AW = $clog2(MAX_PROCS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  apfs_pkg::t_rec    i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output apfs_pkg::t_rec    o_rdata
);
    apfs_pkg::t_rec r_mem [MAX_PROCS];
    apfs_pkg::t_rec r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/arrival_priority_fcfs_scheduler_core.sv
// Process records load one request per cycle, while in the load state, into a table of MAX_PROCS
// entries. The request with tlast closes the set. Ordering is an insertion sort that walks the
// table memory through its single read port: for record i the key is read, then each entry
// below it is read and shifted up until the key's place is found. Emission then reads the table
// in order and waits while the output is busy. Records beyond capacity are dropped and flagged
// on every result of the set.
// depends on apfs_pkg and apfs_table
module arrival_priority_fcfs_scheduler_core #(
    parameter int unsigned MAX_PROCS = apfs_pkg::MaxProcsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // proc_id[15:0], arrival[31:16], burst[47:32]
    input  logic [47:0]  s_axis_tdata,
    // proc_class
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_id[15:0], out_arrival[31:16], out_burst[47:32], waiting[67:48],
    // turnaround[87:68], zero fill[95:88]
    output logic [95:0]  m_axis_tdata,
    // out_class[0], overflow[1]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    localparam int unsigned AW = $clog2(MAX_PROCS);
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_KEY   = 7'b0000010,
        S_KEYW  = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_CMPW  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMITW = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_i, n_i;      // sort outer index, also emit index
    logic [CW-1:0] r_j, n_j;
    apfs_pkg::t_rec r_key, n_key;
    logic [apfs_pkg::ClkW-1:0] r_now, n_now;
    logic          r_ovalid, n_ovalid;
    logic [95:0]   r_odata, n_odata;
    logic [1:0]    r_ouser, n_ouser;
    logic          r_olast, n_olast;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    apfs_pkg::t_rec  wdata, rdata, in_rec;

    apfs_table #(.MAX_PROCS(MAX_PROCS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign in_rec.proc_id    = s_axis_tdata[15:0];
    assign in_rec.arrival    = s_axis_tdata[31:16];
    assign in_rec.burst      = s_axis_tdata[47:32];
    assign in_rec.proc_class = s_axis_tuser;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // sequencer: load, insertion sort over the memory, emit
    always_comb begin
        logic [apfs_pkg::ClkW-1:0] start, done, arr_w;
        logic [CW-1:0] jm1;
        n_state = r_state; n_count = r_count; n_drop = r_drop;
        n_i = r_i; n_j = r_j; n_key = r_key; n_now = r_now;
        n_ovalid = r_ovalid; n_odata = r_odata; n_ouser = r_ouser; n_olast = r_olast;
        we = 1'b0; waddr = '0; wdata = in_rec; raddr = '0;
        arr_w = apfs_pkg::ClkW'(rdata.arrival);
        start = (r_i == '0) ? arr_w : ((r_now < arr_w) ? arr_w : r_now);
        done  = start + apfs_pkg::ClkW'(rdata.burst);
        jm1   = r_j - 1'b1;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_count < CW'(MAX_PROCS)) begin
                        we = 1'b1; waddr = r_count[AW-1:0];
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_i = CW'(1);
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY: begin
                if (r_i >= r_count) begin
                    n_i = '0; n_state = S_EMIT;
                end else begin
                    raddr = r_i[AW-1:0];
                    n_state = S_KEYW;
                end
            end
            S_KEYW: begin
                // key arrives, fetch the entry just below it
                n_key = rdata; n_j = r_i;
                raddr = AW'(r_i - 1'b1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // rdata holds entry j-1
                if (apfs_pkg::runs_before(r_key, rdata)) begin
                    we = 1'b1; waddr = r_j[AW-1:0]; wdata = rdata;
                    n_j = jm1;
                    if (jm1 == '0) begin
                        n_state = S_CMPW;
                    end else begin
                        raddr = AW'(jm1 - 1'b1);
                        n_state = S_CMPW;
                    end
                end else begin
                    we = 1'b1; waddr = r_j[AW-1:0]; wdata = r_key;
                    n_i = r_i + 1'b1;
                    n_state = S_KEY;
                end
            end
            S_CMPW: begin
                if (r_j == '0) begin
                    we = 1'b1; waddr = '0; wdata = r_key;
                    n_i = r_i + 1'b1;
                    n_state = S_KEY;
                end else begin
                    raddr = jm1[AW-1:0];
                    n_state = S_CMP;
                end
            end
            S_EMIT: begin
                raddr = r_i[AW-1:0];
                n_state = S_EMITW;
            end
            S_EMITW: begin
                raddr = r_i[AW-1:0];
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {8'd0, apfs_pkg::StatW'(done - arr_w),
                               apfs_pkg::StatW'(start - arr_w),
                               rdata.burst, rdata.arrival, rdata.proc_id};
                    n_ouser = {r_drop, rdata.proc_class};
                    n_olast = (r_i + 1'b1 == r_count);
                    n_now = done;
                    if (r_i + 1'b1 == r_count) begin
                        n_count = '0; n_drop = 1'b0; n_now = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_count <= '0; r_drop <= 1'b0;
            r_i <= '0; r_j <= '0; r_now <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_drop <= n_drop;
            r_i <= n_i; r_j <= n_j; r_now <= n_now; r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key; r_odata <= n_odata; r_ouser <= n_ouser; r_olast <= n_olast;
    end

    // checks
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS)) else $error("count above capacity");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(r_state == S_EMITW)) else $error("load during emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_odata))
        else $error("result lost while stalled");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMITW && (!r_ovalid || m_axis_tready) && (r_i + 1'b1 == r_count)
        |=> r_state == S_LOAD && r_count == '0)
        else $error("set not closed after last result");
endmodule

// File: test/testbench.sv
// self-checking testbench for arrival_priority_fcfs_scheduler_core
// drives process records over the input stream and checks every scheduled result
// depends on apfs_pkg and the scheduler core
module testbench;

    localparam int unsigned NumProcs = apfs_pkg::MaxProcsDefault;
    localparam int unsigned CycleLimit = 1500000;

    typedef struct {
        logic [15:0] id;
        logic        cls;
        logic [15:0] arr;
        logic [15:0] bur;
        logic [19:0] waiting;
        logic [19:0] turnaround;
        logic        overflow;
        logic        last;
    } t_sched;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // proc_id[15:0], arrival[31:16], burst[47:32]
    logic [47:0] s_axis_tdata;
    // proc_class
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_id[15:0], out_arrival[31:16], out_burst[47:32], waiting[67:48], turnaround[87:68]
    logic [95:0] m_axis_tdata;
    // out_class[0], overflow[1]
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state: records of the open set
    apfs_pkg::t_rec pending_recs[NumProcs];
    int     pending_count;
    logic   pending_dropped;
    t_sched expected_sched[$];
    int     error_count;
    int     cycle_count = 0;
    logic   idle_enable;

    arrival_priority_fcfs_scheduler_core #(.MAX_PROCS(NumProcs)) u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("arrival_priority_fcfs_scheduler_core regression: fail");
            $finish;
        end
    end

    // order the set and compute the schedule
    task automatic schedule_set();
        apfs_pkg::t_rec key;
        t_sched s;
        int     j;
        logic [22:0] now;
        logic [22:0] done;
        for (int i = 1; i < pending_count; i++) begin
            key = pending_recs[i];
            j = i;
            while (j > 0 && ((key.arrival != pending_recs[j-1].arrival) ?
                   (key.arrival < pending_recs[j-1].arrival) :
                   (key.proc_class && !pending_recs[j-1].proc_class))) begin
                pending_recs[j] = pending_recs[j-1];
                j--;
            end
            pending_recs[j] = key;
        end
        now = pending_recs[0].arrival;
        for (int k = 0; k < pending_count; k++) begin
            done = now + pending_recs[k].burst;
            s.id = pending_recs[k].proc_id;
            s.cls = pending_recs[k].proc_class;
            s.arr = pending_recs[k].arrival;
            s.bur = pending_recs[k].burst;
            s.waiting = 20'(now - pending_recs[k].arrival);
            s.turnaround = 20'(done - pending_recs[k].arrival);
            s.overflow = pending_dropped;
            s.last = (k + 1 == pending_count);
            expected_sched.push_back(s);
            now = done;
            if (k + 1 < pending_count && now < pending_recs[k+1].arrival)
                now = pending_recs[k+1].arrival;
        end
        pending_count = 0;
        pending_dropped = 1'b0;
    endtask

    // send one request and update the predictor on acceptance
    task automatic send_record(input logic [15:0] id, input logic cls,
                               input logic [15:0] arr, input logic [15:0] bur,
                               input logic last);
        apfs_pkg::t_rec r;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {bur, arr, id};
        s_axis_tuser <= cls;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r.proc_id = id;
        r.proc_class = cls;
        r.arrival = arr;
        r.burst = bur;
        if (pending_count < NumProcs) begin
            pending_recs[pending_count] = r;
            pending_count++;
        end else begin
            pending_dropped = 1'b1;
        end
        if (last) schedule_set();
        @(negedge i_clk);
    endtask

    // receiver stalls
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sched e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sched.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                e = expected_sched.pop_front();
                if (m_axis_tdata[15:0] !== e.id || m_axis_tuser[0] !== e.cls
                    || m_axis_tdata[31:16] !== e.arr || m_axis_tdata[47:32] !== e.bur
                    || m_axis_tdata[67:48] !== e.waiting
                    || m_axis_tdata[87:68] !== e.turnaround
                    || m_axis_tuser[1] !== e.overflow || m_axis_tlast !== e.last) begin
                    $display("%0t mismatch expected id %h cls %b arr %h bur %h wait %h ta %h ov %b last %b",
                             $time, e.id, e.cls, e.arr, e.bur, e.waiting, e.turnaround,
                             e.overflow, e.last);
                    $display("%0t actual   id %h cls %b arr %h bur %h wait %h ta %h ov %b last %b",
                             $time, m_axis_tdata[15:0], m_axis_tuser[0], m_axis_tdata[31:16],
                             m_axis_tdata[47:32], m_axis_tdata[67:48], m_axis_tdata[87:68],
                             m_axis_tuser[1], m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // stop sending and wait until every expected result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_sched.size() != 0) @(negedge i_clk);
    endtask

    // extremes: min and max fields, single record set, arrival ties and classes
    task automatic test_directed();
        send_record(16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b1);
        send_record(16'hffff, 1'b1, 16'hffff, 16'hffff, 1'b1);
        send_record(16'h0001, 1'b0, 16'h0010, 16'h0005, 1'b0);
        send_record(16'h0002, 1'b1, 16'h0010, 16'h0003, 1'b0);
        send_record(16'h0003, 1'b0, 16'h0010, 16'h0002, 1'b0);
        send_record(16'h0004, 1'b1, 16'h0005, 16'h0001, 1'b0);
        send_record(16'h0005, 1'b0, 16'h0100, 16'h0004, 1'b1);
        wait_drained();
    endtask

    // table full: overflow flag, dropped record that closes the set, large sums
    task automatic test_overflow();
        for (int i = 0; i < 18; i++)
            send_record(16'(16'haa00 + i), 1'(i), 16'h0000, 16'hffff, i == 17);
        wait_drained();
    endtask

    // random sets of random sizes, mostly small
    task automatic test_random(input int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_record(16'($urandom), 1'($urandom),
                            ($urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom)),
                            ($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 30))),
                            i == n - 1);
            sent += n;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        pending_count = 0;
        pending_dropped = 1'b0;
        error_count = 0;
        idle_enable = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_overflow();
        test_random(100);
        idle_enable = 1'b0;
        test_random(30);
        wait_drained();
        repeat (600) @(negedge i_clk);
        if (error_count == 0 && expected_sched.size() == 0) begin
            $display("arrival_priority_fcfs_scheduler_core regression: pass");
        end else begin
            $display("arrival_priority_fcfs_scheduler_core regression: fail");
        end
        $finish;
    end
endmodule
